// ----- rtl/core/iaa_pkg.sv -----
`default_nettype none
package iaa_pkg;

    // function codes of an input beat
    localparam logic [1:0] FN_SCHED   = 2'd0;
    localparam logic [1:0] FN_CLR_ONE = 2'd1;
    localparam logic [1:0] FN_CLR_ALL = 2'd2;

    // fixed field widths
    localparam int PRIO_BITS  = 8;
    localparam int MASK_BITS  = 8;
    localparam int SLOTF_BITS = 3;

    // per-lane control from the sequencer
    typedef struct packed {
        logic age_en;
        logic clr;
    } t_lane_ctl;

endpackage
`default_nettype wire

// ----- rtl/core/inactive_aging_arbiter_core.sv -----
`default_nettype none
// channel   | signals                                             | direction
// ----------+-----------------------------------------------------+----------
// command   | start, busy, i_func, i_ready_mask, i_blocked_mask,  | in (busy out)
//           | i_current_slot, i_target_slot                       |
// result    | o_valid, o_next_slot                                | out
// config    | psel, penable, pwrite, paddr, pwdata, prdata, pready| in/out
//
// each beat is accepted, then the lanes update (aging or clears), then the
// compare tree over the lane ages feeds the result register and winner clear
// o_valid pulses for one cycle in the cycle after; a new beat may be taken then
// the lane adder stage is followed by the merge tree stage
// synchronous active-low reset zeroes all ages and the priority register
// the result side cannot stall; busy holds the command side off while working
module inactive_aging_arbiter_core #(
    parameter int SLOT_COUNT = 8,
    parameter int AGE_BITS   = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [1:0]                      i_func,
    input  wire logic [iaa_pkg::MASK_BITS-1:0]   i_ready_mask,
    input  wire logic [iaa_pkg::MASK_BITS-1:0]   i_blocked_mask,
    input  wire logic [iaa_pkg::SLOTF_BITS-1:0]  i_current_slot,
    input  wire logic [iaa_pkg::SLOTF_BITS-1:0]  i_target_slot,
    output logic                                 o_valid,
    output logic      [iaa_pkg::SLOTF_BITS-1:0]  o_next_slot,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [3:0]                      paddr,
    input  wire logic [63:0]                     pwdata,
    output logic      [63:0]                     prdata,
    output logic                                 pready
);

    localparam int SB = $clog2(SLOT_COUNT);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_AGE   = 2'd1;
    localparam logic [1:0] S_MERGE = 2'd2;

    logic [1:0]                       r_state;
    logic [1:0]                       n_state;
    logic [63:0]                      r_prio;
    logic [1:0]                       r_func;
    logic [iaa_pkg::MASK_BITS-1:0]    r_ready;
    logic [iaa_pkg::MASK_BITS-1:0]    r_blocked;
    logic [iaa_pkg::SLOTF_BITS-1:0]   r_cur;
    logic [iaa_pkg::SLOTF_BITS-1:0]   r_tgt;
    logic                             r_valid;
    logic [iaa_pkg::SLOTF_BITS-1:0]   r_next;
    logic [iaa_pkg::SLOTF_BITS-1:0]   n_next;

    logic                             accept;
    logic [SLOT_COUNT-1:0]            elig;
    logic                             cur_blk;
    logic                             keep_cur;
    logic                             sched;
    logic [AGE_BITS-1:0]              lane_age  [SLOT_COUNT];
    logic [iaa_pkg::PRIO_BITS-1:0]    lane_prio [SLOT_COUNT];
    iaa_pkg::t_lane_ctl               lane_ctl  [SLOT_COUNT];
    logic                             m_found;
    logic [SB-1:0]                    m_win;
    logic [AGE_BITS-1:0]              m_age;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign sched  = (r_func == iaa_pkg::FN_SCHED);

    // config register, one 64-bit word, decoded at paddr[3] == 0 (addresses 0 to 7)
    assign pready = 1'b1;
    assign prdata = (paddr[3] == 1'b0) ? r_prio : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio <= '0;
        end else if (psel && penable && pwrite && pready && (paddr[3] == 1'b0)) begin
            r_prio <= pwdata;
        end
    end

    // command capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func    <= i_func;
            r_ready   <= i_ready_mask;
            r_blocked <= i_blocked_mask;
            r_cur     <= i_current_slot;
            r_tgt     <= i_target_slot;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_AGE;
            S_AGE:   n_state = S_MERGE;
            S_MERGE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_MERGE);
        end
    end

    // eligibility: slot 0 and slots beyond the mask never compete
    always_comb begin
        for (int k = 0; k < SLOT_COUNT; k++) begin
            if (k >= 1 && k < iaa_pkg::MASK_BITS) begin
                elig[k] = r_ready[k[2:0]] & ~r_blocked[k[2:0]];
            end else begin
                elig[k] = 1'b0;
            end
        end
    end

    // lane priorities from the packed register
    for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_lane
        if (k < iaa_pkg::MASK_BITS) begin : g_prio
            assign lane_prio[k] = r_prio[iaa_pkg::PRIO_BITS*k +: iaa_pkg::PRIO_BITS];
        end else begin : g_zero
            assign lane_prio[k] = '0;
        end

        iaa_lane #(
            .AGE_BITS (AGE_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl[k]),
            .i_prio  (lane_prio[k]),
            .o_age   (lane_age[k])
        );
    end

    iaa_merge #(
        .SLOT_COUNT (SLOT_COUNT),
        .AGE_BITS   (AGE_BITS)
    ) u_merge (
        .i_age   (lane_age),
        .i_prio  (lane_prio),
        .i_elig  (elig),
        .o_found (m_found),
        .o_win   (m_win),
        .o_age   (m_age)
    );

    // blocked current slot keeps running when no slot is eligible or the best age is zero
    assign cur_blk  = (int'(r_cur) < SLOT_COUNT) && r_blocked[r_cur];
    assign keep_cur = cur_blk && (!m_found || (m_age == '0));

    // lane controls: update in the age state, winner clear in the merge state
    always_comb begin
        for (int k = 0; k < SLOT_COUNT; k++) begin
            lane_ctl[k].age_en = 1'b0;
            lane_ctl[k].clr    = 1'b0;
            if (r_state == S_AGE) begin
                lane_ctl[k].age_en = sched && elig[k];
                lane_ctl[k].clr    = (r_func == iaa_pkg::FN_CLR_ALL) ||
                                     ((r_func == iaa_pkg::FN_CLR_ONE) && (int'(r_tgt) == k));
            end else if ((r_state == S_MERGE) && sched) begin
                if (keep_cur) begin
                    lane_ctl[k].clr = (int'(r_cur) == k);
                end else begin
                    lane_ctl[k].clr = m_found && (int'(m_win) == k);
                end
            end
        end
    end

    // result selection
    always_comb begin
        n_next = '0;
        if (sched) begin
            if (keep_cur) begin
                n_next = r_cur;
            end else if (m_found) begin
                n_next = iaa_pkg::SLOTF_BITS'(m_win);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MERGE) begin
            r_next <= n_next;
        end
    end

    assign o_valid     = r_valid;
    assign o_next_slot = r_next;

    // a result beat follows exactly one merge cycle
    a_valid_after_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_MERGE))
        else $error("result beat without merge");

    // an accepted beat makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted beat did not raise busy");

    // clear beats return slot zero
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_func != iaa_pkg::FN_SCHED)) |-> (o_next_slot == '0))
        else $error("clear beat returned a nonzero slot");

    // the result strobe never overlaps work in progress
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while busy");

endmodule
`default_nettype wire

// ----- rtl/core/iaa_lane.sv -----
`default_nettype none
module iaa_lane #(
    parameter int AGE_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire iaa_pkg::t_lane_ctl             i_ctl,
    input  wire logic [iaa_pkg::PRIO_BITS-1:0]  i_prio,
    output logic      [AGE_BITS-1:0]            o_age
);

    logic [AGE_BITS-1:0] r_age;
    logic [AGE_BITS-1:0] n_age;

    // age update: clear wins over aging, add wraps
    always_comb begin
        n_age = r_age;
        if (i_ctl.clr) begin
            n_age = '0;
        end else if (i_ctl.age_en) begin
            n_age = r_age + AGE_BITS'(i_prio);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age <= '0;
        end else begin
            r_age <= n_age;
        end
    end

    assign o_age = r_age;

endmodule
`default_nettype wire

// ----- rtl/core/iaa_merge.sv -----
`default_nettype none
module iaa_merge #(
    parameter int SLOT_COUNT = 8,
    parameter int AGE_BITS   = 16,
    localparam int SB        = $clog2(SLOT_COUNT)
) (
    input  wire logic [AGE_BITS-1:0]           i_age  [SLOT_COUNT],
    input  wire logic [iaa_pkg::PRIO_BITS-1:0] i_prio [SLOT_COUNT],
    input  wire logic [SLOT_COUNT-1:0]         i_elig,
    output logic                               o_found,
    output logic      [SB-1:0]                 o_win,
    output logic      [AGE_BITS-1:0]           o_age
);

    localparam int P = 1 << SB;

    // heap-ordered compare tree, leaves at P..2P-1
    logic                           nd_v [1:2*P-1];
    logic [AGE_BITS-1:0]            nd_a [1:2*P-1];
    logic [iaa_pkg::PRIO_BITS-1:0]  nd_p [1:2*P-1];
    logic [SB-1:0]                  nd_i [1:2*P-1];

    // leaves: ineligible lanes and padding carry age zero
    for (genvar j = 0; j < P; j++) begin : g_leaf
        if (j < SLOT_COUNT) begin : g_used
            assign nd_v[P+j] = i_elig[j];
            assign nd_a[P+j] = i_elig[j] ? i_age[j] : '0;
            assign nd_p[P+j] = i_prio[j];
        end else begin : g_pad
            assign nd_v[P+j] = 1'b0;
            assign nd_a[P+j] = '0;
            assign nd_p[P+j] = '0;
        end
        assign nd_i[P+j] = SB'(j);
    end

    // inner nodes: right side takes over only when strictly better
    for (genvar n = 1; n < P; n++) begin : g_node
        logic take_r;
        assign take_r = nd_v[2*n+1] && (!nd_v[2*n] || (nd_a[2*n+1] > nd_a[2*n]) ||
                        ((nd_a[2*n+1] == nd_a[2*n]) && (nd_p[2*n+1] > nd_p[2*n])));
        assign nd_v[n] = nd_v[2*n] | nd_v[2*n+1];
        assign nd_a[n] = take_r ? nd_a[2*n+1] : nd_a[2*n];
        assign nd_p[n] = take_r ? nd_p[2*n+1] : nd_p[2*n];
        assign nd_i[n] = take_r ? nd_i[2*n+1] : nd_i[2*n];
    end

    assign o_found = nd_v[1];
    assign o_win   = nd_i[1];
    assign o_age   = nd_a[1];

endmodule
`default_nettype wire
